// ----- rtl/core/voxel_grid_ray_pick_remove_defines.svh -----
// ----------------------------------------------------------------------------
// voxel grid ray pick/remove: assertion macros
// shared concurrent assertion forms, clocked on clk with reset arst_n
// ----------------------------------------------------------------------------
`ifndef VOXEL_GRID_RAY_PICK_REMOVE_DEFINES_SVH
`define VOXEL_GRID_RAY_PICK_REMOVE_DEFINES_SVH

// same-cycle implication
`define VGR_ASSERT_NOW(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication
`define VGR_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ----- rtl/core/vgr_pkg.sv -----
// ----------------------------------------------------------------------------
// vgr_pkg
// types and constants shared by the voxel grid ray pick/remove block
// ----------------------------------------------------------------------------
package vgr_pkg;

	localparam logic CFG_STEP_SIZE = 1'b0;
	localparam logic CFG_MAX_STEPS = 1'b1;

	localparam logic [15:0] STEP_SIZE_RST = 16'd3277;
	localparam logic [19:0] MAX_STEPS_RST = 20'd20000;

	localparam logic [1:0] MODE_READ  = 2'd0;
	localparam logic [1:0] MODE_WRITE = 2'd1;
	localparam logic [1:0] MODE_RAY   = 2'd2;

	typedef enum logic [1:0] {
		K_READ,
		K_WRITE,
		K_RAY,
		K_NOP
	} kind_t;

	typedef struct packed {
		kind_t              kind;
		logic               in_bounds;
		logic [7:0]         cell_x;
		logic [7:0]         cell_y;
		logic [7:0]         cell_z;
		logic [1:0]         new_type;
		logic signed [31:0] origin_x;
		logic signed [31:0] origin_y;
		logic signed [31:0] origin_z;
		logic signed [23:0] dir_x;
		logic signed [23:0] dir_y;
		logic signed [23:0] dir_z;
	} cmd_t;

	typedef struct packed {
		logic [1:0] read_type;
		logic       hit;
		logic [7:0] hit_x;
		logic [7:0] hit_y;
		logic [7:0] hit_z;
		logic [1:0] removed_type;
	} res_t;

	typedef struct packed {
		logic full;
		logic empty;
	} q_stat_t;

endpackage

// ----- rtl/core/vgr_req_if.sv -----
// ----------------------------------------------------------------------------
// vgr_req_if
// request channel: one beat per read, write or ray pick command
// ----------------------------------------------------------------------------
interface vgr_req_if;
	logic               valid;
	logic               ready;
	logic [1:0]         mode;
	logic [7:0]         cell_x;
	logic [7:0]         cell_y;
	logic [7:0]         cell_z;
	logic [1:0]         new_type;
	logic signed [31:0] origin_x;
	logic signed [31:0] origin_y;
	logic signed [31:0] origin_z;
	logic signed [23:0] dir_x;
	logic signed [23:0] dir_y;
	logic signed [23:0] dir_z;

	modport source (output valid, mode, cell_x, cell_y, cell_z, new_type,
		origin_x, origin_y, origin_z, dir_x, dir_y, dir_z, input ready);
	modport sink (input valid, mode, cell_x, cell_y, cell_z, new_type,
		origin_x, origin_y, origin_z, dir_x, dir_y, dir_z, output ready);
endinterface

// ----- rtl/core/vgr_rsp_if.sv -----
// ----------------------------------------------------------------------------
// vgr_rsp_if
// response channel: one beat per command
// ----------------------------------------------------------------------------
interface vgr_rsp_if;
	logic       valid;
	logic       ready;
	logic [1:0] read_type;
	logic       hit;
	logic [7:0] hit_x;
	logic [7:0] hit_y;
	logic [7:0] hit_z;
	logic [1:0] removed_type;

	modport source (output valid, read_type, hit, hit_x, hit_y, hit_z, removed_type,
		input ready);
	modport sink (input valid, read_type, hit, hit_x, hit_y, hit_z, removed_type,
		output ready);
endinterface

// ----- rtl/core/vgr_front.sv -----
// ----------------------------------------------------------------------------
// vgr_front
// accepts request beats, decodes the mode and checks the cell bounds
// ----------------------------------------------------------------------------
module vgr_front import vgr_pkg::*; #(
	parameter int GRID_EDGE = 16
) (
	vgr_req_if.sink req,
	input  q_stat_t  q_stat,
	input  logic     clearing,
	output logic     push,
	output cmd_t     push_cmd
);

	localparam logic [8:0] EDGE9 = 9'(GRID_EDGE);

	assign req.ready = !q_stat.full && !clearing;
	assign push      = req.valid && req.ready;

	always_comb begin
		push_cmd          = '0;
		push_cmd.cell_x   = req.cell_x;
		push_cmd.cell_y   = req.cell_y;
		push_cmd.cell_z   = req.cell_z;
		push_cmd.new_type = req.new_type;
		push_cmd.origin_x = req.origin_x;
		push_cmd.origin_y = req.origin_y;
		push_cmd.origin_z = req.origin_z;
		push_cmd.dir_x    = req.dir_x;
		push_cmd.dir_y    = req.dir_y;
		push_cmd.dir_z    = req.dir_z;
		push_cmd.in_bounds = (9'(req.cell_x) < EDGE9) && (9'(req.cell_y) < EDGE9)
			&& (9'(req.cell_z) < EDGE9);
		unique case (req.mode)
			MODE_READ:  push_cmd.kind = K_READ;
			MODE_WRITE: push_cmd.kind = K_WRITE;
			MODE_RAY:   push_cmd.kind = K_RAY;
			default:    push_cmd.kind = K_NOP;
		endcase
	end

endmodule

// ----- rtl/core/vgr_cmd_fifo.sv -----
// ----------------------------------------------------------------------------
// vgr_cmd_fifo
// two-entry command queue between front and back
// ----------------------------------------------------------------------------
module vgr_cmd_fifo import vgr_pkg::*; (
	input  logic    clk,
	input  logic    arst_n,
	input  logic    push,
	input  cmd_t    push_cmd,
	input  logic    pop,
	output cmd_t    head,
	output q_stat_t stat
);

	cmd_t       mem_q [2];
	logic       wr_ptr_q;
	logic       rd_ptr_q;
	logic [1:0] count_q;

	assign head       = mem_q[rd_ptr_q];
	assign stat.full  = (count_q == 2'd2);
	assign stat.empty = (count_q == 2'd0);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			count_q  <= 2'd0;
		end else begin
			if (push)
				wr_ptr_q <= !wr_ptr_q;
			if (pop)
				rd_ptr_q <= !rd_ptr_q;
			if (push && !pop)
				count_q <= count_q + 2'd1;
			else if (pop && !push)
				count_q <= count_q - 2'd1;
		end
	end

	always_ff @(posedge clk) begin
		if (push)
			mem_q[wr_ptr_q] <= push_cmd;
	end

endmodule

// ----- rtl/core/vgr_back.sv -----
// ----------------------------------------------------------------------------
// vgr_back
// executes commands against the cell store and marches rays step by step
// ----------------------------------------------------------------------------
module vgr_back import vgr_pkg::*; #(
	parameter int GRID_EDGE  = 16,
	parameter int CELL_UNITS = 16
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic [15:0] step_size,
	input  logic [19:0] max_steps,
	input  cmd_t        head,
	input  q_stat_t     q_stat,
	output logic        pop,
	output logic        clearing,
	vgr_rsp_if.source   rsp
);

	localparam int CELLS = GRID_EDGE * GRID_EDGE * GRID_EDGE;
	localparam int AW    = $clog2(CELLS);
	localparam int EC    = GRID_EDGE * CELL_UNITS;
	localparam int DW    = $clog2(EC) + 1;
	localparam int QW    = $clog2(GRID_EDGE);
	localparam longint NEG_LIM = -(longint'(CELL_UNITS) <<< 32);

	typedef enum logic [7:0] {
		ST_CLR   = 8'b0000_0001,
		ST_IDLE  = 8'b0000_0010,
		ST_RDATA = 8'b0000_0100,
		ST_RAYMUL= 8'b0000_1000,
		ST_ADV   = 8'b0001_0000,
		ST_CELL  = 8'b0010_0000,
		ST_ADDR  = 8'b0100_0000,
		ST_CHK   = 8'b1000_0000
	} state_t;

	state_t             state_q, state_d;
	logic               done_q;
	logic [AW-1:0]      clr_cnt_q;
	logic [19:0]        k_q;
	logic signed [63:0] pos_q   [3];
	logic signed [23:0] dir_q   [3];
	logic signed [40:0] delta_q [3];
	logic [7:0]         cell_s  [3];
	logic [AW-1:0]      idx_s;
	res_t               res_q;
	res_t               out_q;
	logic               out_valid_q;

	logic [1:0]         mem [CELLS];
	logic [1:0]         rdata_q;
	logic               mem_we;
	logic [AW-1:0]      mem_waddr;
	logic [1:0]         mem_wdata;
	logic [AW-1:0]      mem_raddr;

	logic [8:0]         ac [3];
	logic               all_in;
	logic               out_free;

	function automatic logic [AW-1:0] idx_of(input logic [7:0] x, input logic [7:0] y,
		input logic [7:0] z);
		return AW'(x) + AW'(y) * AW'(GRID_EDGE) + AW'(z) * AW'(GRID_EDGE * GRID_EDGE);
	endfunction

	// restoring division by the constant cell size
	function automatic logic [7:0] div_units(input logic [DW-1:0] w);
		logic [DW-1:0] rem;
		logic [DW-1:0] sub;
		logic [7:0]    q;
		rem = w;
		q   = '0;
		for (int i = QW - 1; i >= 0; i--) begin
			sub = DW'(CELL_UNITS) << i;
			if (rem >= sub) begin
				rem  = rem - sub;
				q[i] = 1'b1;
			end
		end
		return q;
	endfunction

	// {in grid, cell} for one axis of a Q.32 position
	function automatic logic [8:0] axis_cell(input logic signed [63:0] p);
		logic [30:0] w;
		w = p[62:32];
		if (p[63])
			return {(p > NEG_LIM), 8'd0};
		return {(w < 31'(EC)), div_units(DW'(w))};
	endfunction

	always_comb begin
		for (int a = 0; a < 3; a++)
			ac[a] = axis_cell(pos_q[a]);
	end
	assign all_in   = ac[0][8] && ac[1][8] && ac[2][8];
	assign out_free = !out_valid_q || rsp.ready;
	assign clearing = (state_q == ST_CLR);

	always_comb begin
		state_d   = state_q;
		pop       = 1'b0;
		mem_we    = 1'b0;
		mem_waddr = idx_of(head.cell_x, head.cell_y, head.cell_z);
		mem_wdata = head.new_type;
		mem_raddr = idx_of(head.cell_x, head.cell_y, head.cell_z);
		unique case (state_q)
			ST_CLR: begin
				mem_we    = 1'b1;
				mem_waddr = clr_cnt_q;
				mem_wdata = 2'd0;
				if (clr_cnt_q == AW'(CELLS - 1))
					state_d = ST_IDLE;
			end
			ST_IDLE: begin
				if (!q_stat.empty && !done_q) begin
					pop = 1'b1;
					unique case (head.kind)
						K_READ:  if (head.in_bounds) state_d = ST_RDATA;
						K_WRITE: mem_we = head.in_bounds;
						K_RAY:   state_d = ST_RAYMUL;
						default: ;
					endcase
				end
			end
			ST_RDATA:  state_d = ST_IDLE;
			ST_RAYMUL: state_d = ST_ADV;
			ST_ADV:    state_d = (k_q >= max_steps) ? ST_IDLE : ST_CELL;
			ST_CELL:   state_d = all_in ? ST_ADDR : ST_ADV;
			ST_ADDR: begin
				mem_raddr = idx_of(cell_s[0], cell_s[1], cell_s[2]);
				state_d   = ST_CHK;
			end
			ST_CHK: begin
				if (rdata_q != 2'd0) begin
					mem_we    = 1'b1;
					mem_waddr = idx_s;
					mem_wdata = 2'd0;
					state_d   = ST_IDLE;
				end else begin
					state_d = ST_ADV;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk) begin
		if (mem_we)
			mem[mem_waddr] <= mem_wdata;
		rdata_q <= mem[mem_raddr];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_CLR;
			clr_cnt_q   <= '0;
			done_q      <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (state_q == ST_CLR)
				clr_cnt_q <= clr_cnt_q + AW'(1);
			// result staged in res_q, moved out when the output slot frees
			if (done_q && out_free) begin
				done_q      <= 1'b0;
				out_valid_q <= 1'b1;
			end else begin
				if (rsp.ready)
					out_valid_q <= 1'b0;
				if ((state_q == ST_IDLE && pop && !(head.kind == K_READ && head.in_bounds)
					&& head.kind != K_RAY) || state_q == ST_RDATA
					|| (state_q == ST_ADV && k_q >= max_steps)
					|| (state_q == ST_CHK && rdata_q != 2'd0))
					done_q <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (done_q && out_free)
			out_q <= res_q;
		unique case (state_q)
			ST_IDLE: begin
				// staged result stays put until a new command is taken
				if (pop) begin
					res_q      <= '0;
					k_q        <= 20'd1;
					pos_q[0]   <= 64'(head.origin_x) <<< 16;
					pos_q[1]   <= 64'(head.origin_y) <<< 16;
					pos_q[2]   <= 64'(head.origin_z) <<< 16;
					dir_q[0]   <= head.dir_x;
					dir_q[1]   <= head.dir_y;
					dir_q[2]   <= head.dir_z;
				end
			end
			ST_RDATA: res_q.read_type <= rdata_q;
			ST_RAYMUL: begin
				for (int a = 0; a < 3; a++)
					delta_q[a] <= 41'(41'(dir_q[a]) * 41'($signed({1'b0, step_size})));
			end
			ST_ADV: begin
				for (int a = 0; a < 3; a++)
					pos_q[a] <= pos_q[a] + 64'(delta_q[a]);
			end
			ST_CELL: begin
				for (int a = 0; a < 3; a++)
					cell_s[a] <= ac[a][7:0];
				if (!all_in)
					k_q <= k_q + 20'd1;
			end
			ST_ADDR: idx_s <= mem_raddr;
			ST_CHK: begin
				if (rdata_q != 2'd0) begin
					res_q.hit          <= 1'b1;
					res_q.hit_x        <= cell_s[0];
					res_q.hit_y        <= cell_s[1];
					res_q.hit_z        <= cell_s[2];
					res_q.removed_type <= rdata_q;
				end else begin
					k_q <= k_q + 20'd1;
				end
			end
			default: ;
		endcase
	end

	assign rsp.valid        = out_valid_q;
	assign rsp.read_type    = out_q.read_type;
	assign rsp.hit          = out_q.hit;
	assign rsp.hit_x        = out_q.hit_x;
	assign rsp.hit_y        = out_q.hit_y;
	assign rsp.hit_z        = out_q.hit_z;
	assign rsp.removed_type = out_q.removed_type;

endmodule

// ----- rtl/core/voxel_grid_ray_pick_remove.sv -----
// ----------------------------------------------------------------------------
// voxel_grid_ray_pick_remove
// cubic voxel store with cell read, cell write and fixed-step ray pick/remove
// ----------------------------------------------------------------------------
// After reset the block sweeps the cell store to air, one cell per cycle, and
// takes no request beat until that pass is done. A
// decode front feeds a two-entry command queue, so requests keep arriving while
// the back end works and a finished response waits in its output register. The
// back end runs one command at a time over a cell store with one read and one
// write port; a ray pick does its setup and then, per step, the add and the cell
// divide, and when the step lands inside the grid also the address and the
// check, up to max_steps - 1 steps.
module voxel_grid_ray_pick_remove import vgr_pkg::*; #(
	parameter int GRID_EDGE  = 16,
	parameter int CELL_UNITS = 16
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_we,
	input  logic        cfg_index,
	input  logic [19:0] cfg_data,
	vgr_req_if.sink     req,
	vgr_rsp_if.source   rsp
);

	`include "voxel_grid_ray_pick_remove_defines.svh"

	logic [15:0] step_size_q;
	logic [19:0] max_steps_q;
	q_stat_t     q_stat;
	logic        clearing;
	logic        push;
	logic        pop;
	cmd_t        push_cmd;
	cmd_t        head;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			step_size_q <= STEP_SIZE_RST;
			max_steps_q <= MAX_STEPS_RST;
		end else if (cfg_we) begin
			case (cfg_index)
				CFG_STEP_SIZE: step_size_q <= cfg_data[15:0];
				CFG_MAX_STEPS: max_steps_q <= cfg_data;
				default: ;
			endcase
		end
	end

	vgr_front #(.GRID_EDGE(GRID_EDGE)) u_front (
		.req      (req),
		.q_stat   (q_stat),
		.clearing (clearing),
		.push     (push),
		.push_cmd (push_cmd)
	);

	vgr_cmd_fifo u_fifo (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (push),
		.push_cmd (push_cmd),
		.pop      (pop),
		.head     (head),
		.stat     (q_stat)
	);

	vgr_back #(.GRID_EDGE(GRID_EDGE), .CELL_UNITS(CELL_UNITS)) u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.step_size (step_size_q),
		.max_steps (max_steps_q),
		.head      (head),
		.q_stat    (q_stat),
		.pop       (pop),
		.clearing  (clearing),
		.rsp       (rsp)
	);

	`VGR_ASSERT_NOW(a_miss_zero, rsp.valid && !rsp.hit, rsp.hit_x == 8'd0 && rsp.hit_y == 8'd0 && rsp.hit_z == 8'd0 && rsp.removed_type == 2'd0, "miss beat with nonzero hit fields")
	`VGR_ASSERT_NOW(a_hit_solid, rsp.valid && rsp.hit, rsp.removed_type != 2'd0 && rsp.read_type == 2'd0, "hit beat with air or read type")
	`VGR_ASSERT_NOW(a_hit_in_grid, rsp.valid && rsp.hit, 9'(rsp.hit_x) < 9'(GRID_EDGE) && 9'(rsp.hit_y) < 9'(GRID_EDGE) && 9'(rsp.hit_z) < 9'(GRID_EDGE), "hit cell outside grid")
	`VGR_ASSERT_NOW(a_clear_blocks, clearing, !req.ready && !pop, "request taken during clear")
	`VGR_ASSERT_NEXT(a_no_pop_empty, q_stat.empty, !pop || push || !q_stat.empty, "pop from empty queue")

endmodule

// ----- tb/voxel_grid_ray_pick_remove_tb.sv -----
// ----------------------------------------------------------------------------
// voxel_grid_ray_pick_remove_tb
// drives read, write and ray pick beats into the voxel block and checks every
// response against a cycle-free model of the cell store and the ray march
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module voxel_grid_ray_pick_remove_tb;
	import vgr_pkg::*;

	localparam int EDGE = 16;
	localparam int UNITS = 16;
	localparam logic [1:0] MODE_NOP = 2'd3;

	typedef struct {
		logic [1:0]         mode;
		logic [7:0]         cx, cy, cz;
		logic [1:0]         nt;
		logic signed [31:0] ox, oy, oz;
		logic signed [23:0] dx, dy, dz;
	} cmd_item_t;

	logic        clk;
	logic        arst_n;
	logic        cfg_we;
	logic        cfg_index;
	logic [19:0] cfg_data;

	vgr_req_if req ();
	vgr_rsp_if rsp ();

	voxel_grid_ray_pick_remove uut (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg_we   (cfg_we),
		.cfg_index(cfg_index),
		.cfg_data (cfg_data),
		.req      (req),
		.rsp      (rsp)
	);

	// model state
	logic [1:0]  cells [EDGE*EDGE*EDGE];
	logic [15:0] m_step;
	logic [19:0] m_max;

	cmd_item_t pending [$];
	res_t      results_due [$];
	cmd_item_t cur;

	int errors;
	int send_idle;
	int recv_stall;
	int stall_left;
	logic stall_go;
	int dir_lim;

	initial clk = 1'b0;
	always #5 clk = ~clk;

	initial begin
		#50_000_000;
		$display("DONE: errors detected");
		$finish;
	end

	function automatic res_t predict_response(cmd_item_t c);
		res_t r;
		longint pos [3];
		longint dlt [3];
		longint cc [3];
		bit in_grid;
		int idx;
		r = '0;
		if (c.mode == MODE_READ) begin
			if (c.cx < EDGE && c.cy < EDGE && c.cz < EDGE)
				r.read_type = cells[c.cx + c.cy*EDGE + c.cz*EDGE*EDGE];
		end else if (c.mode == MODE_WRITE) begin
			if (c.cx < EDGE && c.cy < EDGE && c.cz < EDGE)
				cells[c.cx + c.cy*EDGE + c.cz*EDGE*EDGE] = c.nt;
		end else if (c.mode == MODE_RAY) begin
			pos[0] = longint'(c.ox) * 65536;
			pos[1] = longint'(c.oy) * 65536;
			pos[2] = longint'(c.oz) * 65536;
			dlt[0] = longint'(c.dx) * longint'({1'b0, m_step});
			dlt[1] = longint'(c.dy) * longint'({1'b0, m_step});
			dlt[2] = longint'(c.dz) * longint'({1'b0, m_step});
			for (int k = 1; k < int'(m_max); k++) begin
				in_grid = 1'b1;
				for (int a = 0; a < 3; a++) begin
					pos[a] += dlt[a];
					// both divisions truncate toward zero
					cc[a] = (pos[a] / (64'sd1 <<< 32)) / UNITS;
					if (cc[a] < 0 || cc[a] >= EDGE) in_grid = 1'b0;
				end
				if (in_grid) begin
					idx = int'(cc[0] + cc[1]*EDGE + cc[2]*EDGE*EDGE);
					if (cells[idx] != 2'd0) begin
						r.hit = 1'b1;
						r.hit_x = cc[0][7:0];
						r.hit_y = cc[1][7:0];
						r.hit_z = cc[2][7:0];
						r.removed_type = cells[idx];
						cells[idx] = 2'd0;
						break;
					end
				end
			end
		end
		return r;
	endfunction

	// request driver
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			req.valid <= 1'b0;
		end else begin
			if (req.valid && req.ready)
				results_due.push_back(predict_response(cur));
			if (!req.valid || req.ready) begin
				if (pending.size() > 0 && $urandom_range(99) >= send_idle) begin
					cur = pending.pop_front();
					req.mode     <= cur.mode;
					req.cell_x   <= cur.cx;
					req.cell_y   <= cur.cy;
					req.cell_z   <= cur.cz;
					req.new_type <= cur.nt;
					req.origin_x <= cur.ox;
					req.origin_y <= cur.oy;
					req.origin_z <= cur.oz;
					req.dir_x    <= cur.dx;
					req.dir_y    <= cur.dy;
					req.dir_z    <= cur.dz;
					req.valid    <= 1'b1;
				end else begin
					req.valid <= 1'b0;
				end
			end
		end
	end

	// long receiver hold-off
	always @(posedge clk) begin
		if (stall_go)
			stall_left <= 400;
		else if (stall_left > 0)
			stall_left <= stall_left - 1;
	end

	task automatic report(string what, int got, int want);
		errors++;
		$display("mismatch %s: got %0d expected %0d at %0t", what, got, want, $realtime);
	endtask

	// response monitor
	always @(posedge clk or negedge arst_n) begin
		res_t want;
		if (!arst_n) begin
			rsp.ready <= 1'b0;
		end else begin
			if (rsp.valid && rsp.ready) begin
				if (results_due.size() == 0) begin
					report("unexpected beat", 1, 0);
				end else begin
					want = results_due.pop_front();
					if (rsp.read_type !== want.read_type)
						report("read_type", rsp.read_type, want.read_type);
					if (rsp.hit !== want.hit) report("hit", rsp.hit, want.hit);
					if (rsp.hit_x !== want.hit_x) report("hit_x", rsp.hit_x, want.hit_x);
					if (rsp.hit_y !== want.hit_y) report("hit_y", rsp.hit_y, want.hit_y);
					if (rsp.hit_z !== want.hit_z) report("hit_z", rsp.hit_z, want.hit_z);
					if (rsp.removed_type !== want.removed_type)
						report("removed_type", rsp.removed_type, want.removed_type);
				end
			end
			rsp.ready <= (stall_left == 0) && ($urandom_range(99) >= recv_stall);
		end
	end

	task automatic write_reg(logic idx, logic [19:0] v);
		@(posedge clk);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= v;
		@(posedge clk);
		cfg_we <= 1'b0;
		if (idx == CFG_STEP_SIZE) m_step = v[15:0];
		else m_max = v;
	endtask

	task automatic wait_idle();
		while (pending.size() > 0 || req.valid || results_due.size() > 0)
			@(posedge clk);
		repeat (10) @(posedge clk);
	endtask

	function automatic cmd_item_t mk(logic [1:0] md, int x, int y, int z, int t);
		cmd_item_t c;
		c = '{default: '0};
		c.mode = md;
		c.cx = x;
		c.cy = y;
		c.cz = z;
		c.nt = t;
		return c;
	endfunction

	function automatic cmd_item_t mk_ray(int ox, int oy, int oz, int dx, int dy, int dz);
		cmd_item_t c;
		c = mk(MODE_RAY, 0, 0, 0, 0);
		c.ox = ox;
		c.oy = oy;
		c.oz = oz;
		c.dx = dx;
		c.dy = dy;
		c.dz = dz;
		return c;
	endfunction

	function automatic int rand_origin();
		int u;
		u = $urandom_range(0, 320);
		return ((u - 32) <<< 16) | $urandom_range(0, 65535);
	endfunction

	function automatic int rand_dir();
		return $urandom_range(0, 2*dir_lim) - dir_lim;
	endfunction

	function automatic cmd_item_t rand_item();
		cmd_item_t c;
		int pick;
		pick = $urandom_range(99);
		if (pick < 32) begin
			c = mk(MODE_WRITE, $urandom_range(0, 15), $urandom_range(0, 15),
				$urandom_range(0, 15), $urandom_range(0, 3));
		end else if (pick < 47) begin
			c = mk(MODE_READ, $urandom_range(0, 15), $urandom_range(0, 15),
				$urandom_range(0, 15), 0);
		end else if (pick < 87) begin
			c = mk_ray(rand_origin(), rand_origin(), rand_origin(),
				rand_dir(), rand_dir(), rand_dir());
		end else begin
			// noise: every bit of every field free
			c.mode = $urandom_range(0, 3);
			c.cx = $urandom;
			c.cy = $urandom;
			c.cz = $urandom;
			c.nt = $urandom;
			c.ox = $urandom;
			c.oy = $urandom;
			c.oz = $urandom;
			c.dx = $urandom;
			c.dy = $urandom;
			c.dz = $urandom;
		end
		return c;
	endfunction

	task automatic run_phase(int n, int s_idle, int r_stall, int step, int maxs, int lim);
		write_reg(CFG_STEP_SIZE, step);
		write_reg(CFG_MAX_STEPS, maxs);
		send_idle = s_idle;
		recv_stall = r_stall;
		dir_lim = lim;
		for (int i = 0; i < n; i++) begin
			pending.push_back(rand_item());
			if (i % 100 == 99) wait_idle();
		end
		wait_idle();
	endtask

	initial begin
		errors = 0;
		send_idle = 0;
		recv_stall = 0;
		stall_left = 0;
		stall_go = 1'b0;
		dir_lim = 1 << 16;
		cfg_we = 1'b0;
		cfg_index = CFG_STEP_SIZE;
		cfg_data = '0;
		req.valid = 1'b0;
		req.mode = MODE_READ;
		req.cell_x = '0;
		req.cell_y = '0;
		req.cell_z = '0;
		req.new_type = '0;
		req.origin_x = '0;
		req.origin_y = '0;
		req.origin_z = '0;
		req.dir_x = '0;
		req.dir_y = '0;
		req.dir_z = '0;
		rsp.ready = 1'b0;
		for (int i = 0; i < EDGE*EDGE*EDGE; i++) cells[i] = 2'd0;
		m_step = STEP_SIZE_RST;
		m_max = MAX_STEPS_RST;
		arst_n = 1'b0;
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;

		// directed, reset register values
		pending.push_back(mk(MODE_WRITE, 0, 0, 0, 1));
		pending.push_back(mk(MODE_WRITE, 15, 15, 15, 3));
		pending.push_back(mk(MODE_WRITE, 15, 0, 7, 2));
		pending.push_back(mk(MODE_WRITE, 16, 0, 0, 1));
		pending.push_back(mk(MODE_WRITE, 0, 255, 0, 2));
		pending.push_back(mk(MODE_READ, 0, 0, 0, 0));
		pending.push_back(mk(MODE_READ, 15, 15, 15, 0));
		pending.push_back(mk(MODE_READ, 15, 0, 7, 0));
		pending.push_back(mk(MODE_READ, 16, 0, 0, 0));
		pending.push_back(mk(MODE_READ, 255, 255, 255, 0));
		pending.push_back(mk(MODE_READ, 3, 3, 3, 0));
		cur = mk_ray(-1, 32'h7fffffff, 5 << 16, 24'h7fffff, 24'h800000, 3);
		cur.mode = MODE_NOP;
		cur.cx = 8'hff;
		cur.nt = 2'd3;
		pending.push_back(cur);
		pending.push_back(mk_ray(8 << 16, 8 << 16, 8 << 16, 0, 0, 0));
		pending.push_back(mk_ray(248 << 16, 248 << 16, 248 << 16, 1, 1, 1));
		wait_idle();

		// zero step, tiny and huge step counts
		write_reg(CFG_STEP_SIZE, 0);
		write_reg(CFG_MAX_STEPS, 1);
		pending.push_back(mk(MODE_WRITE, 1, 1, 1, 2));
		pending.push_back(mk_ray(24 << 16, 24 << 16, 24 << 16, 5, 5, 5));
		wait_idle();
		write_reg(CFG_MAX_STEPS, 0);
		pending.push_back(mk_ray(24 << 16, 24 << 16, 24 << 16, 5, 5, 5));
		wait_idle();
		write_reg(CFG_MAX_STEPS, 20'hfffff);
		pending.push_back(mk_ray(24 << 16, 24 << 16, 24 << 16, -7, 3, 0));
		wait_idle();
		write_reg(CFG_STEP_SIZE, 16'hffff);
		write_reg(CFG_MAX_STEPS, 4);
		pending.push_back(mk_ray(32'h7fffffff, 32'h80000000, 0,
			24'h7fffff, 24'h800000, 24'h7fffff));
		pending.push_back(mk_ray(32'h80000000, 32'h7fffffff, 32'hffffffff,
			24'h800000, 24'h7fffff, 24'h800000));
		wait_idle();

		// random phases
		run_phase(400, 0, 0, 16'hffff, 48, 12 << 16);
		run_phase(400, 67, 0, STEP_SIZE_RST, 100, 24'h7fffff);
		// receiver holds off while the sender keeps offering beats
		send_idle = 0;
		recv_stall = 67;
		stall_go <= 1'b1;
		@(posedge clk);
		stall_go <= 1'b0;
		for (int i = 0; i < 60; i++) pending.push_back(rand_item());
		wait_idle();
		run_phase(340, 0, 67, 1, 8, 24'h7fffff);
		run_phase(400, 7, 7, $urandom_range(1, 65535), $urandom_range(2, 64), 20 << 16);

		wait_idle();
		repeat (50) @(posedge clk);
		if (errors == 0)
			$display("DONE: 0 errors");
		else
			$display("DONE: errors detected");
		$finish;
	end

endmodule
